>>> rtl/tdpf_pkg.sv
package tdpf_pkg;

  localparam int unsigned TableDepth = 6542;
  localparam int unsigned NumW       = 32;
  localparam int unsigned FactW      = 32;
  localparam int unsigned ExpW       = 5;
  localparam int unsigned PrimeW     = 17;
  localparam int unsigned SieveW     = 16;
  localparam int unsigned InTdataW   = 32;
  localparam int unsigned OutTdataW  = 40;

  function automatic int unsigned addr_w(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int unsigned idx_w(input int unsigned n);
    return $clog2(n + 1);
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_TSTART,
    ST_TWAIT,
    ST_CHKREM,
    ST_DIVOUT,
    ST_RWAIT,
    ST_EMIT,
    ST_NEXT,
    ST_LEFT
  } step_e;

  typedef enum logic [3:0] {
    C_FALSE,
    C_TRUE,
    C_IN_ACC,
    C_NUM_LE1,
    C_IDX_END,
    C_DIV_IDLE,
    C_Q_LT_P,
    C_REM_Z,
    C_REM_NZ,
    C_COF_ONE,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    cond_e wait_c;
    cond_e br_c;
    step_e target;
    step_e next;
    logic  ld_input;
    logic  rd_mem;
    logic  div_test;
    logic  div_again;
    logic  emit_prime;
    logic  emit_left;
    logic  inc_idx;
  } uword_t;

  typedef struct packed {
    logic              start;
    logic [NumW-1:0]   dividend;
    logic [PrimeW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [NumW-1:0]   quot;
    logic [PrimeW-1:0] rem;
  } div_res_t;

  // A step waits on wait_c, then jumps to target when br_c holds and falls through to next.
  function automatic uword_t ucode(input step_e s);
    uword_t w;
    w = '0;
    w.wait_c = C_TRUE;
    w.br_c   = C_FALSE;
    w.target = ST_IDLE;
    w.next   = ST_IDLE;
    case (s)
      ST_IDLE: begin
        w.wait_c   = C_IN_ACC;
        w.br_c     = C_NUM_LE1;
        w.target   = ST_LEFT;
        w.next     = ST_FETCH;
        w.ld_input = 1'b1;
      end
      ST_FETCH: begin
        w.br_c   = C_IDX_END;
        w.target = ST_LEFT;
        w.next   = ST_TSTART;
        w.rd_mem = 1'b1;
      end
      ST_TSTART: begin
        w.next     = ST_TWAIT;
        w.div_test = 1'b1;
      end
      ST_TWAIT: begin
        w.wait_c = C_DIV_IDLE;
        w.br_c   = C_Q_LT_P;
        w.target = ST_LEFT;
        w.next   = ST_CHKREM;
      end
      ST_CHKREM: begin
        w.br_c   = C_REM_NZ;
        w.target = ST_NEXT;
        w.next   = ST_DIVOUT;
      end
      ST_DIVOUT: begin
        w.next      = ST_RWAIT;
        w.div_again = 1'b1;
      end
      ST_RWAIT: begin
        w.wait_c = C_DIV_IDLE;
        w.br_c   = C_REM_Z;
        w.target = ST_DIVOUT;
        w.next   = ST_EMIT;
      end
      ST_EMIT: begin
        w.wait_c     = C_OUT_FREE;
        w.br_c       = C_COF_ONE;
        w.target     = ST_IDLE;
        w.next       = ST_NEXT;
        w.emit_prime = 1'b1;
      end
      ST_NEXT: begin
        w.next    = ST_FETCH;
        w.inc_idx = 1'b1;
      end
      ST_LEFT: begin
        w.wait_c    = C_OUT_FREE;
        w.br_c      = C_TRUE;
        w.target    = ST_IDLE;
        w.emit_left = 1'b1;
      end
      default: begin
        w.br_c   = C_TRUE;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/tdpf_divider.sv
module tdpf_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdpf_pkg::div_req_t req_i,
  output tdpf_pkg::div_res_t res_o
);

  localparam int unsigned Steps = tdpf_pkg::NumW / 2;
  localparam int unsigned CntW  = $clog2(Steps);

  logic                        busy_q;
  logic [CntW-1:0]             cnt_q;
  logic [tdpf_pkg::NumW-1:0]   quot_q, quot_d;
  logic [tdpf_pkg::PrimeW-1:0] rem_q, rem_d;
  logic [tdpf_pkg::PrimeW-1:0] dvs_q;

  // Two restoring steps per cycle.
  always_comb begin
    logic [tdpf_pkg::PrimeW:0]   t;
    logic [tdpf_pkg::PrimeW-1:0] r;
    logic [tdpf_pkg::NumW-1:0]   q;
    r = rem_q;
    q = quot_q;
    for (int k = 0; k < 2; k++) begin
      t = {r, q[tdpf_pkg::NumW-1]};
      q = {q[tdpf_pkg::NumW-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        t    = t - {1'b0, dvs_q};
        q[0] = 1'b1;
      end
      r = t[tdpf_pkg::PrimeW-1:0];
    end
    rem_d  = r;
    quot_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign res_o.busy = busy_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

>>> rtl/tdpf_table.sv
module tdpf_table #(
  parameter int unsigned NumPrimes = tdpf_pkg::TableDepth
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     rd_en_i,
  input  logic [tdpf_pkg::addr_w(NumPrimes)-1:0]   rd_idx_i,
  output logic [tdpf_pkg::PrimeW-1:0]              prime_o,
  output logic                                     ready_o
);

  localparam int unsigned AddrW  = tdpf_pkg::addr_w(NumPrimes);
  localparam int unsigned IdxW   = tdpf_pkg::idx_w(NumPrimes);
  localparam int unsigned SieveW = tdpf_pkg::SieveW;
  localparam int unsigned RootW  = SieveW / 2;
  localparam int unsigned SieveN = 2 ** SieveW;

  typedef enum logic [2:0] {
    T_CLEAR,
    T_RD_I,
    T_CHK_I,
    T_MARK,
    T_RD_K,
    T_CHK_K,
    T_DONE
  } tstate_e;

  tstate_e             state_q;
  logic [SieveW-1:0]   cnt_q;
  logic [RootW-1:0]    i_q;
  logic [SieveW:0]     j_q;
  logic [IdxW-1:0]     n_q;

  logic                mark_mem [SieveN];
  logic                mark_rd_q;
  logic                mark_we, mark_wd, mark_re;
  logic [SieveW-1:0]   mark_wa, mark_ra;

  logic [tdpf_pkg::PrimeW-1:0] prime_mem [NumPrimes];
  logic [tdpf_pkg::PrimeW-1:0] prime_rd_q;
  logic                        prime_we;

  logic [SieveW-1:0]   sq;
  logic [SieveW:0]     j_next;
  logic                i_last;

  assign sq      = SieveW'(i_q) * SieveW'(i_q);
  assign j_next  = j_q + (SieveW + 1)'(i_q);
  assign i_last  = (i_q == '1);

  assign mark_we  = (state_q == T_CLEAR) || (state_q == T_MARK);
  assign mark_wd  = (state_q == T_MARK);
  assign mark_wa  = (state_q == T_CLEAR) ? cnt_q : j_q[SieveW-1:0];
  assign mark_re  = (state_q == T_RD_I) || (state_q == T_RD_K);
  assign mark_ra  = (state_q == T_RD_I) ? SieveW'(i_q) : cnt_q;
  assign prime_we = (state_q == T_CHK_K) && !mark_rd_q;

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (mark_re) begin
      mark_rd_q <= mark_mem[mark_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prime_we) begin
      prime_mem[n_q[AddrW-1:0]] <= tdpf_pkg::PrimeW'(cnt_q);
    end
    if (rd_en_i) begin
      prime_rd_q <= prime_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_CLEAR;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
    end else begin
      case (state_q)
        T_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '1) begin
            i_q     <= RootW'(2);
            state_q <= T_RD_I;
          end
        end
        T_RD_I: begin
          state_q <= T_CHK_I;
        end
        T_CHK_I: begin
          if (!mark_rd_q) begin
            j_q     <= (SieveW + 1)'(sq);
            state_q <= T_MARK;
          end else if (i_last) begin
            cnt_q   <= SieveW'(2);
            state_q <= T_RD_K;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= T_RD_I;
          end
        end
        T_MARK: begin
          if (!j_next[SieveW]) begin
            j_q <= j_next;
          end else if (i_last) begin
            cnt_q   <= SieveW'(2);
            state_q <= T_RD_K;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= T_RD_I;
          end
        end
        T_RD_K: begin
          state_q <= T_CHK_K;
        end
        T_CHK_K: begin
          if (!mark_rd_q) begin
            n_q <= n_q + 1'b1;
          end
          if ((!mark_rd_q && (n_q == IdxW'(NumPrimes - 1))) || (cnt_q == '1)) begin
            state_q <= T_DONE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= T_RD_K;
          end
        end
        T_DONE: begin
          state_q <= T_DONE;
        end
        default: begin
          state_q <= T_CLEAR;
        end
      endcase
    end
  end

  assign prime_o = prime_rd_q;
  assign ready_o = (state_q == T_DONE);

endmodule

>>> rtl/tdpf_useq.sv
module tdpf_useq #(
  parameter int unsigned NumPrimes = tdpf_pkg::TableDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   table_ready_i,
  input  logic [tdpf_pkg::PrimeW-1:0]            prime_i,
  output logic                                   rd_en_o,
  output logic [tdpf_pkg::addr_w(NumPrimes)-1:0] rd_idx_o,
  output tdpf_pkg::div_req_t                     div_req_o,
  input  tdpf_pkg::div_res_t                     div_res_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [tdpf_pkg::InTdataW-1:0]          s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [tdpf_pkg::OutTdataW-1:0]         m_axis_tdata_o,
  output logic                                   m_axis_tlast_o
);

  localparam int unsigned AddrW = tdpf_pkg::addr_w(NumPrimes);
  localparam int unsigned IdxW  = tdpf_pkg::idx_w(NumPrimes);
  localparam int unsigned NumW  = tdpf_pkg::NumW;
  localparam int unsigned ExpW  = tdpf_pkg::ExpW;
  localparam int unsigned FactW = tdpf_pkg::FactW;
  localparam int unsigned PadW  = tdpf_pkg::OutTdataW - FactW - ExpW;

  tdpf_pkg::step_e  step_q, step_d;
  tdpf_pkg::uword_t uw;
  logic [NumW-1:0]  cof_q;
  logic [IdxW-1:0]  idx_q;
  logic [ExpW-1:0]  mult_q;
  logic             out_valid_q;
  logic [FactW-1:0] out_fact_q;
  logic [ExpW-1:0]  out_exp_q;
  logic             out_last_q;

  logic [15:0]      cond_vec;
  logic             fire, taken;

  assign s_axis_tready_o = (step_q == tdpf_pkg::ST_IDLE) && table_ready_i;

  always_comb begin
    cond_vec                       = '0;
    cond_vec[tdpf_pkg::C_FALSE]    = 1'b0;
    cond_vec[tdpf_pkg::C_TRUE]     = 1'b1;
    cond_vec[tdpf_pkg::C_IN_ACC]   = s_axis_tvalid_i && s_axis_tready_o;
    cond_vec[tdpf_pkg::C_NUM_LE1]  = (s_axis_tdata_i[NumW-1:1] == '0);
    cond_vec[tdpf_pkg::C_IDX_END]  = (idx_q == IdxW'(NumPrimes));
    cond_vec[tdpf_pkg::C_DIV_IDLE] = !div_res_i.busy;
    cond_vec[tdpf_pkg::C_Q_LT_P]   = (div_res_i.quot < NumW'(prime_i));
    cond_vec[tdpf_pkg::C_REM_Z]    = (div_res_i.rem == '0);
    cond_vec[tdpf_pkg::C_REM_NZ]   = (div_res_i.rem != '0);
    cond_vec[tdpf_pkg::C_COF_ONE]  = (cof_q == NumW'(1));
    cond_vec[tdpf_pkg::C_OUT_FREE] = !out_valid_q || m_axis_tready_i;
  end

  assign uw     = tdpf_pkg::ucode(step_q);
  assign fire   = cond_vec[uw.wait_c];
  assign taken  = cond_vec[uw.br_c];
  assign step_d = !fire ? step_q : (taken ? uw.target : uw.next);

  assign rd_en_o  = fire && uw.rd_mem && !taken;
  assign rd_idx_o = idx_q[AddrW-1:0];

  assign div_req_o.start    = fire && (uw.div_test || uw.div_again);
  assign div_req_o.dividend = uw.div_again ? div_res_i.quot : cof_q;
  assign div_req_o.divisor  = prime_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= tdpf_pkg::ST_IDLE;
      cof_q       <= '0;
      idx_q       <= '0;
      mult_q      <= '0;
      out_valid_q <= 1'b0;
      out_fact_q  <= '0;
      out_exp_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        if (uw.ld_input) begin
          cof_q  <= s_axis_tdata_i[NumW-1:0];
          idx_q  <= '0;
          mult_q <= '0;
        end
        if (uw.div_again) begin
          cof_q  <= div_res_i.quot;
          mult_q <= mult_q + 1'b1;
        end
        if (uw.inc_idx) begin
          idx_q <= idx_q + 1'b1;
        end
        if (uw.emit_prime) begin
          mult_q      <= '0;
          out_valid_q <= 1'b1;
          out_fact_q  <= FactW'(prime_i);
          out_exp_q   <= mult_q;
          out_last_q  <= (cof_q == NumW'(1));
        end
        if (uw.emit_left) begin
          out_valid_q <= 1'b1;
          out_fact_q  <= cof_q;
          out_exp_q   <= ExpW'(1);
          out_last_q  <= 1'b1;
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_exp_q, out_fact_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> rtl/trial_division_prime_factorizer_core.sv
// After reset the prime table is built by a sieve; s_axis_tready_o stays low while the
// bitmap is cleared, marked and scanned.
// Inputs 0 and 1 give a single transaction, registered from ST_LEFT once the output is free.
// Every tried table prime costs one divider run, and every further division by a dividing
// prime another; the two-bits-per-cycle divider sets the time of each run.
// Reset is asynchronous and active low; it clears the sequencer and restarts the table build.
module trial_division_prime_factorizer_core #(
  parameter int unsigned NumPrimes = tdpf_pkg::TableDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tdpf_pkg::InTdataW-1:0]  s_axis_tdata_i,   // [31:0] number
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [tdpf_pkg::OutTdataW-1:0] m_axis_tdata_o,   // [31:0] factor, [36:32] exponent
  output logic                           m_axis_tlast_o
);

  // The table never holds more primes than the sieve can supply.
  localparam int unsigned NumEntries =
    (NumPrimes < tdpf_pkg::TableDepth) ? NumPrimes : tdpf_pkg::TableDepth;

  logic                                    table_ready;
  logic                                    rd_en;
  logic [tdpf_pkg::addr_w(NumEntries)-1:0] rd_idx;
  logic [tdpf_pkg::PrimeW-1:0]             prime;
  tdpf_pkg::div_req_t                      div_req;
  tdpf_pkg::div_res_t                      div_res;

  tdpf_table #(
    .NumPrimes (NumEntries)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx),
    .prime_o  (prime),
    .ready_o  (table_ready)
  );

  tdpf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  tdpf_useq #(
    .NumPrimes (NumEntries)
  ) u_useq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .table_ready_i   (table_ready),
    .prime_i         (prime),
    .rd_en_o         (rd_en),
    .rd_idx_o        (rd_idx),
    .div_req_o       (div_req),
    .div_res_i       (div_res),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

>>> rtl/tdpf_checker.sv
module tdpf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [tdpf_pkg::OutTdataW-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);

  localparam int unsigned FactW = tdpf_pkg::FactW;
  localparam int unsigned ExpW  = tdpf_pkg::ExpW;
  localparam int unsigned OutW  = tdpf_pkg::OutTdataW;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("Stalled output transaction changed.");

  a_exp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[FactW+ExpW-1:FactW] != '0)
    else $error("Output exponent is zero.");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutW-1:FactW+ExpW] == '0)
    else $error("Output padding bits are not zero.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("Input accepted again right after a transaction.");

  a_small_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[FactW-1:1] == '0) |->
      m_axis_tlast_o && (m_axis_tdata_o[FactW+ExpW-1:FactW] == ExpW'(1)))
    else $error("Factor 0 or 1 is not a single final transaction.");

endmodule

bind trial_division_prime_factorizer_core tdpf_checker u_tdpf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
